### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the sentence framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/nsfc_pkg.sv
// Package with the character codes, limits, phase type and hex decoder of the framer.
package nsfc_pkg;

  // Character codes of the sentence delimiters.
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Longest sentence that is counted; longer ones saturate and are flagged.
  localparam int unsigned MAX_LEN   = 128;
  localparam logic [7:0]  MAX_COUNT = 8'(MAX_LEN);

  // Checksum phase: summing until the star, gathering hex digits, then done.
  typedef enum logic [2:0] {
    PH_SUM  = 3'b001,
    PH_HEX  = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  // Result of decoding one ASCII character as a hex digit.
  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  // Decodes 0-9, A-F and a-f; any other character gives ok low.
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.ok    = 1'b0;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok    = 1'b1;
      r.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r.ok    = 1'b1;
      r.value = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return r;
  endfunction

endpackage

### hw/rtl/nmea_sentence_framer_checker_unit.sv
// Top level of the NMEA sentence framer and checksum checker.
//
// The block takes one received byte per cycle and gives one result per byte
// inside a sentence (from the dollar through the newline); bytes outside a
// sentence are dropped and give no result. Each request is resolved in the
// cycle it is accepted and lands in a single output register, so a result
// appears in the cycle after its byte and a new byte is taken in every cycle.
// The input is stalled only while that output register holds a result that
// the downstream side is stalling. On the newline, is_last is high and the
// summary fields (length, computed and received checksums, match, star and
// overflow flags) are valid; on other bytes the summary fields read zero.
module nmea_sentence_framer_checker_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] sentence_byte,
  output logic       is_last,
  output logic [7:0] sentence_length,
  output logic       checksum_match,
  output logic [7:0] computed_sum,
  output logic [7:0] received_sum,
  output logic       star_found,
  output logic       length_overflow
);

  import nsfc_pkg::*;

  // Sentence state.
  logic       in_sentence, in_sentence_next;
  phase_t     check_phase, check_phase_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] hex_accum, hex_accum_next;
  logic       hex_overflow, hex_overflow_next;
  logic [7:0] byte_count, byte_count_next;
  logic       count_overflow, count_overflow_next;

  // Result produced by the current request.
  logic       emit;
  logic       last_next;
  logic [7:0] length_next;
  logic       match_next;
  logic [7:0] computed_next;
  logic [7:0] received_next;
  logic       star_next;
  logic       overflow_next;

  logic       in_accept;
  hex_digit_t digit;

  // A request is taken whenever the output register is free or being drained.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign digit     = hex_decode(rx_byte);

  // Next state and result for the incoming byte.
  always_comb begin
    in_sentence_next    = in_sentence;
    check_phase_next    = check_phase;
    running_xor_next    = running_xor;
    hex_accum_next      = hex_accum;
    hex_overflow_next   = hex_overflow;
    byte_count_next     = byte_count;
    count_overflow_next = count_overflow;
    emit          = 1'b0;
    last_next     = 1'b0;
    length_next   = 8'd0;
    match_next    = 1'b0;
    computed_next = 8'd0;
    received_next = 8'd0;
    star_next     = 1'b0;
    overflow_next = 1'b0;
    if (!in_sentence) begin
      if (rx_byte == CH_DOLLAR) begin
        emit                = 1'b1;
        in_sentence_next    = 1'b1;
        check_phase_next    = PH_SUM;
        running_xor_next    = 8'd0;
        hex_accum_next      = 8'd0;
        hex_overflow_next   = 1'b0;
        byte_count_next     = 8'd1;
        count_overflow_next = 1'b0;
      end
    end else begin
      emit = 1'b1;
      if (byte_count < MAX_COUNT) begin
        byte_count_next = byte_count + 8'd1;
      end else begin
        count_overflow_next = 1'b1;
      end
      if (rx_byte == CH_NEWLINE) begin
        // Close the sentence and report its summary.
        last_next     = 1'b1;
        length_next   = byte_count_next;
        star_next     = (check_phase != PH_SUM);
        match_next    = star_next && !hex_overflow && (hex_accum == running_xor);
        computed_next = running_xor;
        received_next = hex_accum;
        overflow_next = count_overflow_next;
        in_sentence_next    = 1'b0;
        check_phase_next    = PH_SUM;
        running_xor_next    = 8'd0;
        hex_accum_next      = 8'd0;
        hex_overflow_next   = 1'b0;
        byte_count_next     = 8'd0;
        count_overflow_next = 1'b0;
      end else begin
        unique case (check_phase)
          PH_SUM: begin
            if (rx_byte == CH_STAR) begin
              check_phase_next = PH_HEX;
            end else begin
              running_xor_next = running_xor ^ rx_byte;
            end
          end
          PH_HEX: begin
            if (digit.ok) begin
              if (hex_accum[7:4] != 4'd0) begin
                hex_overflow_next = 1'b1;
              end
              hex_accum_next = {hex_accum[3:0], digit.value};
            end else begin
              check_phase_next = PH_DONE;
            end
          end
          PH_DONE: begin
            check_phase_next = PH_DONE;
          end
          default: begin
            check_phase_next = PH_SUM;
          end
        endcase
      end
    end
  end

  // Sentence state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence    <= 1'b0;
      check_phase    <= PH_SUM;
      running_xor    <= 8'd0;
      hex_accum      <= 8'd0;
      hex_overflow   <= 1'b0;
      byte_count     <= 8'd0;
      count_overflow <= 1'b0;
    end else if (in_accept) begin
      in_sentence    <= in_sentence_next;
      check_phase    <= check_phase_next;
      running_xor    <= running_xor_next;
      hex_accum      <= hex_accum_next;
      hex_overflow   <= hex_overflow_next;
      byte_count     <= byte_count_next;
      count_overflow <= count_overflow_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sentence_byte   <= rx_byte;
      is_last         <= last_next;
      sentence_length <= length_next;
      checksum_match  <= match_next;
      computed_sum    <= computed_next;
      received_sum    <= received_next;
      star_found      <= star_next;
      length_overflow <= overflow_next;
    end
  end

`include "assert_macros.svh"

  // A closing result carries the newline byte.
  `ASSERT_SAME(a_last_is_newline, clk, rst, out_valid && is_last,
      sentence_byte == CH_NEWLINE, "is_last on a byte other than newline")

  // Length and the match, star and overflow flags stay zero on bytes that do not close a sentence.
  `ASSERT_SAME(a_summary_zero, clk, rst, out_valid && !is_last,
      sentence_length == 8'd0 && !checksum_match && !star_found && !length_overflow,
      "summary field set on a byte that is not last")

  // A match is only reported on a closing byte of a sentence with a star.
  `ASSERT_SAME(a_match_needs_star, clk, rst, out_valid && checksum_match,
      star_found && is_last, "checksum match without star or not last")

  // An accepted newline inside a sentence closes it.
  `ASSERT_NEXT(a_newline_closes, clk, rst,
      in_accept && in_sentence && rx_byte == CH_NEWLINE,
      !in_sentence && out_valid && is_last, "newline did not close the sentence")

endmodule
